// ----- rtl/spectral_peak_dissonance_defines.svh -----
// assertion macros for the spectral peak dissonance rtl
`ifndef SPECTRAL_PEAK_DISSONANCE_DEFINES_SVH
`define SPECTRAL_PEAK_DISSONANCE_DEFINES_SVH
`ifndef SYNTHESIS
`define SPD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spd check failed");
`define SPD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spd check failed");
`else
`define SPD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SPD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/spd_pkg.sv -----
// shared types, constants and tables of the spectral peak dissonance block
package spd_pkg;

  localparam int DEF_PEAK_DEPTH  = 128;
  localparam int DEF_MAX_TOP_BIN = 1024;
  localparam int DEF_PAIR_SPAN   = 20;
  localparam int QUEUE_DEPTH     = 4;
  localparam int REG_IDX_W       = 3;

  localparam logic [10:0] RST_TOP_BIN      = 11'd512;
  localparam logic [15:0] RST_FREQ_PER_BIN = 16'd21;
  localparam logic [7:0]  RST_MAX_PEAKS    = 8'd100;
  localparam logic [31:0] RST_PEAK_THRESH  = 32'd0;
  localparam logic [31:0] RST_NORM_GAIN    = 32'd167772;
  localparam logic [15:0] RST_CLAMP_LIMIT  = 16'd1;

  // critical bandwidth denominator 21*f + 486400 in q16.8 hz
  localparam logic [28:0] DEN_SLOPE  = 29'd21;
  localparam logic [28:0] DEN_OFFSET = 29'd486400;
  localparam int          EXP_BITS   = 19;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TOP_BIN        = 3'd0,
    REG_FREQ_PER_BIN   = 3'd1,
    REG_MAX_PEAKS      = 3'd2,
    REG_PEAK_THRESHOLD = 3'd3,
    REG_NORM_GAIN      = 3'd4,
    REG_CLAMP_LIMIT    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] top_bin;
    logic [15:0] freq_per_bin;
    logic [7:0]  max_peaks;
    logic [31:0] peak_threshold;
    logic [31:0] norm_gain;
    logic [15:0] clamp_limit;
  } cfg_t;

  // exp(-2^(b-16)) in q0.30
  function automatic logic [29:0] exp_factor(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd1073725440;
      5'd1:    v = 30'd1073709056;
      5'd2:    v = 30'd1073676290;
      5'd3:    v = 30'd1073610760;
      5'd4:    v = 30'd1073479712;
      5'd5:    v = 30'd1073217664;
      5'd6:    v = 30'd1072693760;
      5'd7:    v = 30'd1071646719;
      5'd8:    v = 30'd1069555701;
      5'd9:    v = 30'd1065385899;
      5'd10:   v = 30'd1057095000;
      5'd11:   v = 30'd1040706261;
      5'd12:   v = 30'd1008687096;
      5'd13:   v = 30'd947573834;
      5'd14:   v = 30'd836230973;
      5'd15:   v = 30'd651257337;
      5'd16:   v = 30'd395007542;
      5'd17:   v = 30'd145315154;
      5'd18:   v = 30'd19666267;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/spd_front.sv -----
// front end: bin power, three point peak detection and queue writes
module spd_front import spd_pkg::*; #(
  parameter int PEAK_DEPTH  = DEF_PEAK_DEPTH,
  parameter int MAX_TOP_BIN = DEF_MAX_TOP_BIN,
  localparam int CW = $clog2(MAX_TOP_BIN + 2),
  localparam int PW = $clog2(PEAK_DEPTH + 1),
  localparam int EW = 2 + CW + 96
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   s_tdata,   // bin_real[15:0], bin_imag[31:16]
  input  logic          s_tlast,   // frame_end
  output logic          q_wr,
  output logic [EW-1:0] q_data,
  input  logic          q_full
);

  logic [CW-1:0] bin_counter;
  logic [31:0]   prev_power;
  logic [31:0]   now_power;
  logic [PW-1:0] peaks_found;

  logic signed [15:0] re, im;
  logic signed [31:0] re_sq, im_sq;
  logic [31:0]        power;
  logic               accept, in_range, room, is_peak;
  logic [CW-1:0]      cand;

  assign re    = s_tdata[15:0];
  assign im    = s_tdata[31:16];
  assign re_sq = re * re;
  assign im_sq = im * im;
  assign power = unsigned'(re_sq) + unsigned'(im_sq);

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign in_range = (32'(bin_counter) <= 32'(cfg.top_bin)) &&
                    (32'(bin_counter) <= 32'(MAX_TOP_BIN));
  assign room     = (32'(peaks_found) < 32'(cfg.max_peaks)) &&
                    (32'(peaks_found) < 32'(PEAK_DEPTH));
  assign is_peak  = in_range && (32'(bin_counter) >= 32'd3) && room &&
                    (now_power > cfg.peak_threshold) && (now_power > prev_power) &&
                    (now_power > power);
  assign cand     = bin_counter - CW'(1);

  // one queue entry carries a peak, a frame end, or both
  assign q_wr   = accept && (is_peak || s_tlast);
  assign q_data = {s_tlast, is_peak, cand, prev_power, now_power, power};

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_counter <= CW'(1);
      prev_power  <= '0;
      now_power   <= '0;
      peaks_found <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        bin_counter <= CW'(1);
        prev_power  <= '0;
        now_power   <= '0;
        peaks_found <= '0;
      end else begin
        if (in_range) begin
          prev_power <= now_power;
          now_power  <= power;
        end
        if (32'(bin_counter) <= 32'(MAX_TOP_BIN)) begin
          bin_counter <= bin_counter + CW'(1);
        end
        if (is_peak) begin
          peaks_found <= peaks_found + PW'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/spd_queue.sv -----
// short shift queue between the front end and the back end
module spd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [NW-1:0]    count;
  logic [NW-1:0]    wr_pos;

  assign full    = (32'(count) == 32'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entry[0];
  assign wr_pos  = count - NW'(rd);

  // a write into the slot being shifted takes priority over the shift
  always_ff @(posedge clk) begin
    for (int idx = 0; idx < DEPTH - 1; idx++) begin
      if (wr && (32'(wr_pos) == idx)) begin
        entry[idx] <= wr_data;
      end else if (rd) begin
        entry[idx] <= entry[idx + 1];
      end
    end
    if (wr && (32'(wr_pos) == DEPTH - 1)) begin
      entry[DEPTH-1] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + NW'(wr) - NW'(rd);
    end
  end

endmodule

// ----- rtl/spd_back.sv -----
// back end: peak refinement, peak store, pair dissonance sum and scaling
`include "spectral_peak_dissonance_defines.svh"
module spd_back import spd_pkg::*; #(
  parameter int PEAK_DEPTH  = DEF_PEAK_DEPTH,
  parameter int MAX_TOP_BIN = DEF_MAX_TOP_BIN,
  parameter int PAIR_SPAN   = DEF_PAIR_SPAN,
  localparam int CW = $clog2(MAX_TOP_BIN + 2),
  localparam int PW = $clog2(PEAK_DEPTH + 1),
  localparam int EW = 2 + CW + 96
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          q_empty,
  input  logic [EW-1:0] q_data,
  output logic          q_rd,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [39:0]   m_tdata    // dissonance[31:0], peak_count[39:32]
);

  localparam int AW = $clog2(PEAK_DEPTH);
  localparam int FW = CW + 25;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_MULA, S_MULB, S_MULC, S_DIV, S_FREQ, S_AMP, S_SQRT, S_WR,
    S_PAIR_I, S_PAIR_I2, S_PAIR_DEN, S_PAIR_K, S_PAIR_K2, S_EXP_SET, S_EXP, S_G,
    S_ACC1, S_ACC2, S_ACC3, S_SCALE1, S_SCALE2, S_SCALE3
  } state_t;

  typedef enum logic [1:0] {DIV_OFF, DIV_AMP, DIV_X} div_sel_t;

  state_t   state;
  div_sel_t div_sel;

  // current queue entry
  logic          is_end_r;
  logic [CW-1:0] cand;
  logic [31:0]   p_r, m_r, n_r;

  // peak refinement
  logic [33:0]    d_r;
  logic [31:0]    q_r;
  logic           sgn_r;
  logic [47:0]    num_r;
  logic [63:0]    sq_r;
  logic [CW+15:0] base_r;
  logic [23:0]    f_r;

  // shared divider
  logic [79:0] rem;
  logic [80:0] dsh;
  logic [45:0] quo;
  logic [5:0]  cnt;

  // square root
  logic [49:0] sv, sr, sb;

  // pair loop
  logic [PW-1:0] n_st, i_r, k_r;
  logic [23:0]   f1, v1, v2;
  logic [28:0]   den;
  logic [19:0]   et, t2_r;
  logic [30:0]   acc, e1, e2;
  logic [4:0]    eb;
  logic          e_second;
  logic [16:0]   g_r;
  logic [47:0]   vv;
  logic [48:0]   prod_a;
  logic [16:0]   prod_b;
  logic [63:0]   sum;

  // scaling and output
  logic        ovf;
  logic [63:0] prod_hi;
  logic [31:0] prod_lo;
  logic        out_valid;
  logic [31:0] out_diss;
  logic [7:0]  out_cnt;

  // peak store
  logic [23:0]   freq_mem [PEAK_DEPTH];
  logic [23:0]   amp_mem  [PEAK_DEPTH];
  logic [AW-1:0] rd_addr;
  logic [23:0]   rd_f, rd_v;
  logic          mem_we;

  logic          div_take;
  logic [FW-1:0] fv;
  logic [50:0]   sq_trial;
  logic [31:0]   kend;
  logic [23:0]   diff;
  logic [61:0]   exp_prod;
  logic [30:0]   acc_step, e_val;
  logic [30:0]   g_raw;
  logic [63:0]   res, lim;
  logic          out_free;

  assign q_rd     = (state == S_IDLE) && !q_empty;
  assign mem_we   = (state == S_WR);
  assign rd_addr  = (state == S_PAIR_I) ? i_r[AW-1:0] : k_r[AW-1:0];
  assign div_take = ({1'b0, rem} >= dsh);
  assign fv       = sgn_r ? FW'({base_r, 8'b0}) + FW'(quo[23:0])
                          : FW'({base_r, 8'b0}) - FW'(quo[23:0]);
  assign sq_trial = 51'(sr) + 51'(sb);
  assign kend     = (32'(i_r) + 32'(PAIR_SPAN) < 32'(n_st)) ?
                    32'(i_r) + 32'(PAIR_SPAN) : 32'(n_st);
  assign diff     = (rd_f > f1) ? rd_f - f1 : 24'd0;
  assign exp_prod = 62'(acc) * 62'(exp_factor(eb)) + (62'(1) << 29);
  assign acc_step = et[eb] ? 31'(exp_prod >> 30) : acc;
  // exponent of eight or more underflows to zero
  assign e_val    = et[19] ? 31'd0 : acc_step;
  assign g_raw    = (e1 > e2) ? e1 - e2 : 31'd0;
  assign res      = prod_hi + 64'(prod_lo);
  assign lim      = 64'(cfg.clamp_limit) << 16;
  assign out_free = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_cnt, out_diss};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      freq_mem[n_st[AW-1:0]] <= f_r;
      amp_mem[n_st[AW-1:0]]  <= sr[23:0];
    end
    rd_f <= freq_mem[rd_addr];
    rd_v <= amp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_sel   <= DIV_OFF;
      n_st      <= '0;
      i_r       <= '0;
      k_r       <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
      e_second  <= 1'b0;
      cnt       <= '0;
    end else begin
      if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            {is_end_r, sgn_r, cand, p_r, m_r, n_r} <= q_data;
            i_r <= '0;
            if (q_data[EW-2]) begin
              state <= S_PREP;
            end else begin
              state <= S_PAIR_I;
            end
          end
        end
        S_PREP: begin
          d_r   <= {1'b0, m_r, 1'b0} - 34'(p_r) - 34'(n_r);
          q_r   <= (n_r >= p_r) ? n_r - p_r : p_r - n_r;
          sgn_r <= (n_r >= p_r);
          state <= S_MULA;
        end
        S_MULA: begin
          num_r <= 48'(q_r) * 48'(cfg.freq_per_bin);
          state <= S_MULB;
        end
        S_MULB: begin
          sq_r  <= 64'(q_r) * 64'(q_r);
          state <= S_MULC;
        end
        S_MULC: begin
          base_r  <= (CW+16)'(cand) * (CW+16)'(cfg.freq_per_bin);
          // interpolation offset: (num * 2^8 + d) / (2d)
          rem     <= 80'({num_r, 8'b0}) + 80'(d_r);
          dsh     <= 81'({d_r, 1'b0}) << 23;
          quo     <= '0;
          cnt     <= 6'd24;
          div_sel <= DIV_OFF;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_take) begin
            rem <= rem - dsh[79:0];
            quo <= {quo[44:0], 1'b1};
          end else begin
            quo <= {quo[44:0], 1'b0};
          end
          dsh <= dsh >> 1;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            case (div_sel)
              DIV_OFF: state <= S_FREQ;
              DIV_AMP: state <= S_AMP;
              DIV_X:   state <= S_EXP_SET;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_FREQ: begin
          f_r     <= (fv > FW'(24'hFFFFFF)) ? 24'hFFFFFF : fv[23:0];
          // amplitude fraction: q^2 * 2^16 / (8d)
          rem     <= {sq_r, 16'b0};
          dsh     <= 81'({d_r, 3'b0}) << 45;
          quo     <= '0;
          cnt     <= 6'd46;
          div_sel <= DIV_AMP;
          state   <= S_DIV;
        end
        S_AMP: begin
          sv    <= 50'({m_r, 16'b0}) + 50'(quo);
          sr    <= '0;
          sb    <= 50'(1) << 48;
          cnt   <= 6'd25;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if ({1'b0, sv} >= sq_trial) begin
            sv <= sv - sr - sb;
            sr <= (sr >> 1) + sb;
          end else begin
            sr <= sr >> 1;
          end
          sb  <= sb >> 2;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          n_st <= n_st + PW'(1);
          if (is_end_r) begin
            state <= S_PAIR_I;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAIR_I: begin
          if (32'(i_r) + 32'd1 < 32'(n_st)) begin
            state <= S_PAIR_I2;
          end else begin
            state <= S_SCALE1;
          end
        end
        S_PAIR_I2: begin
          f1    <= rd_f;
          v1    <= rd_v;
          state <= S_PAIR_DEN;
        end
        S_PAIR_DEN: begin
          den   <= 29'(f1) * DEN_SLOPE + DEN_OFFSET;
          k_r   <= i_r + PW'(1);
          state <= S_PAIR_K;
        end
        S_PAIR_K: begin
          if (32'(k_r) < kend) begin
            state <= S_PAIR_K2;
          end else begin
            i_r   <= i_r + PW'(1);
            state <= S_PAIR_I;
          end
        end
        S_PAIR_K2: begin
          // past an octave ends the inner walk
          if (25'(rd_f) > {f1, 1'b0}) begin
            i_r   <= i_r + PW'(1);
            state <= S_PAIR_I;
          end else begin
            v2      <= rd_v;
            rem     <= 80'(29'(diff) * 29'(24)) << 16;
            dsh     <= 81'(den) << 16;
            quo     <= '0;
            cnt     <= 6'd17;
            div_sel <= DIV_X;
            state   <= S_DIV;
          end
        end
        S_EXP_SET: begin
          et       <= 20'((20'(quo[16:0]) * 20'd7) >> 1);
          t2_r     <= 20'((21'(quo[16:0]) * 21'd23) >> 2);
          acc      <= 31'(1) << 30;
          eb       <= '0;
          e_second <= 1'b0;
          state    <= S_EXP;
        end
        S_EXP: begin
          acc <= acc_step;
          eb  <= eb + 5'd1;
          if (32'(eb) == EXP_BITS - 1) begin
            if (!e_second) begin
              e1       <= e_val;
              et       <= t2_r;
              acc      <= 31'(1) << 30;
              eb       <= '0;
              e_second <= 1'b1;
            end else begin
              e2    <= e_val;
              state <= S_G;
            end
          end
        end
        S_G: begin
          g_r   <= 17'((32'(g_raw) + 32'd8192) >> 14);
          vv    <= 48'(v1) * 48'(v2);
          state <= S_ACC1;
        end
        S_ACC1: begin
          prod_a <= 49'(vv[47:16]) * 49'(g_r);
          state  <= S_ACC2;
        end
        S_ACC2: begin
          sum    <= sum + 64'(prod_a);
          prod_b <= 17'((33'(vv[15:0]) * 33'(g_r)) >> 16);
          state  <= S_ACC3;
        end
        S_ACC3: begin
          sum   <= sum + 64'(prod_b);
          k_r   <= k_r + PW'(1);
          state <= S_PAIR_K;
        end
        S_SCALE1: begin
          ovf     <= (sum[63:56] != 8'd0);
          prod_hi <= 64'(sum[55:24]) * 64'(cfg.norm_gain);
          state   <= S_SCALE2;
        end
        S_SCALE2: begin
          prod_lo <= 32'((56'(sum[23:0]) * 56'(cfg.norm_gain)) >> 24);
          state   <= S_SCALE3;
        end
        S_SCALE3: begin
          if (out_free) begin
            if (cfg.norm_gain == 32'd0) begin
              out_diss <= 32'd0;
            end else if (ovf || (res >= lim)) begin
              out_diss <= lim[31:0];
            end else begin
              out_diss <= res[31:0];
            end
            out_cnt   <= (32'(n_st) > 32'd255) ? 8'hFF : 8'(n_st);
            out_valid <= 1'b1;
            n_st      <= '0;
            sum       <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SPD_ASSERT_IMP(a_store_room, clk, rst, state == S_WR, 32'(n_st) < 32'(PEAK_DEPTH))
  `SPD_ASSERT_IMP(a_pair_order, clk, rst, state == S_PAIR_K2, k_r > i_r)
  `SPD_ASSERT_NXT(a_result_loaded, clk, rst, state == S_SCALE3 && out_free, m_tvalid)

endmodule

// ----- rtl/spectral_peak_dissonance.sv -----
// top level of the spectral peak dissonance block
//
//  channel   handshake            payload
//  s_*       s_tvalid/s_tready    s_tdata bin_real, bin_imag; s_tlast frame_end
//  m_*       m_tvalid/m_tready    m_tdata dissonance, peak_count
//  config    wr_en                wr_index, wr_data
//
//  the front end takes one bin per cycle while the queue has room
//  each peak takes two divider passes and a root in the back end
//  each pair takes a divider pass and the two exponentials
//  a frame end runs the pair loop and the scaling before the result is loaded
//  the queue holds four transactions and the front end stalls while it is full
//  synchronous reset restores register defaults and empties all frame state
module spectral_peak_dissonance import spd_pkg::*; #(
  parameter int PEAK_DEPTH  = DEF_PEAK_DEPTH,
  parameter int MAX_TOP_BIN = DEF_MAX_TOP_BIN,
  parameter int PAIR_SPAN   = DEF_PAIR_SPAN
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // bin_real[15:0], bin_imag[31:16]
  input  logic                 s_tlast,   // frame_end
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,   // dissonance[31:0], peak_count[39:32]
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [31:0]          wr_data
);

  localparam int CW = $clog2(MAX_TOP_BIN + 2);
  localparam int EW = 2 + CW + 96;

  cfg_t          cfg;
  logic          q_wr, q_full, q_rd, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.top_bin        <= RST_TOP_BIN;
      cfg.freq_per_bin   <= RST_FREQ_PER_BIN;
      cfg.max_peaks      <= RST_MAX_PEAKS;
      cfg.peak_threshold <= RST_PEAK_THRESH;
      cfg.norm_gain      <= RST_NORM_GAIN;
      cfg.clamp_limit    <= RST_CLAMP_LIMIT;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_TOP_BIN:        cfg.top_bin        <= wr_data[10:0];
        REG_FREQ_PER_BIN:   cfg.freq_per_bin   <= wr_data[15:0];
        REG_MAX_PEAKS:      cfg.max_peaks      <= wr_data[7:0];
        REG_PEAK_THRESHOLD: cfg.peak_threshold <= wr_data;
        REG_NORM_GAIN:      cfg.norm_gain      <= wr_data;
        REG_CLAMP_LIMIT:    cfg.clamp_limit    <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  spd_front #(
    .PEAK_DEPTH  (PEAK_DEPTH),
    .MAX_TOP_BIN (MAX_TOP_BIN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_wr     (q_wr),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  spd_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  spd_back #(
    .PEAK_DEPTH  (PEAK_DEPTH),
    .MAX_TOP_BIN (MAX_TOP_BIN),
    .PAIR_SPAN   (PAIR_SPAN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_rd     (q_rd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
